// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

   localparam int OpW = 5;
   localparam int DataW = 32;

   localparam logic [OpW-1:0] OP_ADD     = 5'd0;
   localparam logic [OpW-1:0] OP_SUB     = 5'd1;
   localparam logic [OpW-1:0] OP_MUL     = 5'd2;
   localparam logic [OpW-1:0] OP_DIV     = 5'd3;
   localparam logic [OpW-1:0] OP_NEG     = 5'd4;
   localparam logic [OpW-1:0] OP_INC     = 5'd5;
   localparam logic [OpW-1:0] OP_DEC     = 5'd6;
   localparam logic [OpW-1:0] OP_LT      = 5'd7;
   localparam logic [OpW-1:0] OP_GT      = 5'd8;
   localparam logic [OpW-1:0] OP_LE      = 5'd9;
   localparam logic [OpW-1:0] OP_GE      = 5'd10;
   localparam logic [OpW-1:0] OP_EQ      = 5'd11;
   localparam logic [OpW-1:0] OP_NE      = 5'd12;
   localparam logic [OpW-1:0] OP_MIN     = 5'd13;
   localparam logic [OpW-1:0] OP_MAX     = 5'd14;
   localparam logic [OpW-1:0] OP_TOINT   = 5'd15;
   localparam logic [OpW-1:0] OP_FROMINT = 5'd16;

   // control carried alongside each item through the divider row
   typedef struct packed {
      logic valid;
      logic is_div;
      logic neg_q;
      logic div_zero;
   } ctl_type;

endpackage

// ===== rtl/fixed_point_alu.sv =====
// Channel | Direction | tdata (low bit up)          | tuser
// req     | in        | operand_a[31:0], operand_b  | op[4:0]
// rsp     | out       | value[31:0]                 | status
//
// Each item passes from req transfer to rsp valid through, in order:
// one front stage (every non-divide op, divide setup), FRAC_BITS + 32 division cells
// (one quotient bit each), one output register. One item per cycle when rsp
// does not stall. Reset is synchronous and empties every stage. A stall on
// rsp holds the output register; stages behind it keep advancing into empty slots.
module fixed_point_alu import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  logic [4:0]    req_tuser,   // op[4:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // value[31:0]
   output logic          rsp_tuser    // status
);

   localparam int DivW = DataW + FRAC_BITS;
   localparam int NCells = DivW;

   ctl_type            ctl   [0:NCells];
   logic [DataW-1:0]   val   [0:NCells];
   logic [DataW-1:0]   bmag  [0:NCells];
   logic [DataW-1:0]   rem   [0:NCells];
   logic [DivW-1:0]    dq    [0:NCells];
   logic               rdy   [0:NCells];

   logic               rsp_valid_ff;
   logic [DataW-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               out_ready;
   logic [DataW-1:0]   quot;

   // front stage: decode, simple ops, full product
   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_a      (req_tdata[31:0]),
      .in_b      (req_tdata[63:32]),
      .out_ready (rdy[0]),
      .out_ctl   (ctl[0]),
      .out_val   (val[0]),
      .out_bmag  (bmag[0]),
      .out_dq    (dq[0])
   );

   // remainder starts clear at the head of the row
   assign rem[0] = '0;

   // row of division cells; non-divide items just ride along
   for (genvar i = 0; i < NCells; i++) begin : g_cell
      fpa_cell #(.DIV_W(DivW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl[i]),
         .in_ready  (rdy[i]),
         .in_val    (val[i]),
         .in_bmag   (bmag[i]),
         .in_rem    (rem[i]),
         .in_dq     (dq[i]),
         .out_ready (rdy[i+1]),
         .out_ctl   (ctl[i+1]),
         .out_val   (val[i+1]),
         .out_bmag  (bmag[i+1]),
         .out_rem   (rem[i+1]),
         .out_dq    (dq[i+1])
      );
   end

   assign out_ready    = !rsp_valid_ff || rsp_tready;
   assign rdy[NCells]  = out_ready;

   // dq now holds the unsigned quotient; keep the low word, apply sign
   always_comb begin
      quot = dq[NCells][DataW-1:0];
      rsp_status_in = 1'b0;
      if (ctl[NCells].is_div) begin
         if (ctl[NCells].div_zero) begin
            rsp_value_in  = '0;
            rsp_status_in = 1'b1;
         end else begin
            rsp_value_in = ctl[NCells].neg_q ? (~quot + 1'b1) : quot;
         end
      end else begin
         rsp_value_in = val[NCells];
      end
   end

   // output register: hold while stalled, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= ctl[NCells].valid;
      end
      if (out_ready) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTH
   a_zero_on_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("divide-by-zero result not zero");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !ctl[NCells].valid |-> rdy[NCells-1])
      else $error("last cell blocked with empty output");
`endif

endmodule

// ===== rtl/fpa_front.sv =====
module fpa_front import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [OpW-1:0]                in_op,
   input  logic signed [DataW-1:0]       in_a,
   input  logic signed [DataW-1:0]       in_b,
   input  logic                          out_ready,
   output ctl_type                       out_ctl,
   output logic [DataW-1:0]              out_val,
   output logic [DataW-1:0]              out_bmag,
   output logic [DataW+FRAC_BITS-1:0]    out_dq
);

   localparam int DivW = DataW + FRAC_BITS;

   ctl_type                 ctl_ff, ctl_in;
   logic [DataW-1:0]        val_ff, val_in;
   logic signed [2*DataW-1:0] prod_ff, prod_in;
   logic                    mul_ff, mul_in;
   logic [DataW-1:0]        bmag_ff, bmag_in;
   logic [DivW-1:0]         dq_ff, dq_in;
   logic [DataW-1:0]        amag;
   logic [DataW-1:0]        round_add;

   assign in_ready = !ctl_ff.valid || out_ready;

   always_comb begin
      amag      = in_a[DataW-1] ? (~in_a + 1'b1) : in_a;
      round_add = in_a[DataW-1] ? DataW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
      prod_in   = in_a * in_b;
      mul_in    = (in_op == OP_MUL);
      bmag_in   = in_b[DataW-1] ? (~in_b + 1'b1) : in_b;
      dq_in     = {amag, {FRAC_BITS{1'b0}}};
      ctl_in.valid    = in_valid;
      ctl_in.is_div   = (in_op == OP_DIV);
      ctl_in.neg_q    = in_a[DataW-1] ^ in_b[DataW-1];
      ctl_in.div_zero = (in_b == '0);
      val_in = '0;
      unique case (in_op)
         OP_ADD:     val_in = in_a + in_b;
         OP_SUB:     val_in = in_a - in_b;
         OP_NEG:     val_in = -in_a;
         OP_INC:     val_in = in_a + 1;
         OP_DEC:     val_in = in_a - 1;
         OP_LT:      val_in = DataW'(in_a < in_b);
         OP_GT:      val_in = DataW'(in_a > in_b);
         OP_LE:      val_in = DataW'(in_a <= in_b);
         OP_GE:      val_in = DataW'(in_a >= in_b);
         OP_EQ:      val_in = DataW'(in_a == in_b);
         OP_NE:      val_in = DataW'(in_a != in_b);
         OP_MIN:     val_in = (in_a < in_b) ? in_a : in_b;
         OP_MAX:     val_in = (in_a > in_b) ? in_a : in_b;
         OP_TOINT:   val_in = DataW'((in_a + $signed(round_add)) >>> FRAC_BITS);
         OP_FROMINT: val_in = in_a << FRAC_BITS;
         default:    val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= ctl_in;
      end
      if (in_ready) begin
         val_ff  <= val_in;
         prod_ff <= prod_in;
         mul_ff  <= mul_in;
         bmag_ff <= bmag_in;
         dq_ff   <= dq_in;
      end
   end

   // product scaled here, after its register
   assign out_ctl  = ctl_ff;
   assign out_val  = mul_ff ? prod_ff[FRAC_BITS+DataW-1:FRAC_BITS] : val_ff;
   assign out_bmag = bmag_ff;
   assign out_dq   = dq_ff;

endmodule

// ===== rtl/fpa_cell.sv =====
module fpa_cell import fpa_pkg::*; #(
   parameter int DIV_W = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            in_ctl,
   output logic               in_ready,
   input  logic [DataW-1:0]   in_val,
   input  logic [DataW-1:0]   in_bmag,
   input  logic [DataW-1:0]   in_rem,
   input  logic [DIV_W-1:0]   in_dq,
   input  logic               out_ready,
   output ctl_type            out_ctl,
   output logic [DataW-1:0]   out_val,
   output logic [DataW-1:0]   out_bmag,
   output logic [DataW-1:0]   out_rem,
   output logic [DIV_W-1:0]   out_dq
);

   ctl_type            ctl_ff;
   logic [DataW-1:0]   val_ff, bmag_ff, rem_ff, rem_in;
   logic [DIV_W-1:0]   dq_ff, dq_in;
   logic [DataW:0]     rem_sh, diff;
   logic               q_bit;

   assign in_ready = !ctl_ff.valid || out_ready;

   // one restoring step: bring down a dividend bit, subtract if it fits
   always_comb begin
      rem_sh = {in_rem, in_dq[DIV_W-1]};
      diff   = rem_sh - {1'b0, in_bmag};
      q_bit  = !diff[DataW];
      rem_in = q_bit ? diff[DataW-1:0] : rem_sh[DataW-1:0];
      dq_in  = {in_dq[DIV_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
      if (in_ready) begin
         val_ff  <= in_val;
         bmag_ff <= in_bmag;
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_val  = val_ff;
   assign out_bmag = bmag_ff;
   assign out_rem  = rem_ff;
   assign out_dq   = dq_ff;

endmodule

// ===== tb/sv/fpa_checker.sv =====
module fpa_checker import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          rsp_count
);

   typedef struct packed {
      logic [31:0] value;
      logic        status;
   } alu_result_type;

   alu_result_type expected_results[$];

   function automatic alu_result_type compute_alu(logic [4:0] op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type res;
      logic signed [63:0] wide;
      longint sa, sb;
      sa = a;
      sb = b;
      res.status = 1'b0;
      res.value = '0;
      case (op)
         OP_ADD: res.value = a + b;
         OP_SUB: res.value = a - b;
         OP_MUL: begin
            wide = sa * sb;
            wide = wide >>> FRAC_BITS;
            res.value = wide[31:0];
         end
         OP_DIV: begin
            if (b == 0) begin
               res.status = 1'b1;
            end else begin
               wide = (sa * (64'sd1 <<< FRAC_BITS)) / sb;
               res.value = wide[31:0];
            end
         end
         OP_NEG: res.value = -a;
         OP_INC: res.value = a + 1;
         OP_DEC: res.value = a - 1;
         OP_LT: res.value = {31'd0, a < b};
         OP_GT: res.value = {31'd0, a > b};
         OP_LE: res.value = {31'd0, a <= b};
         OP_GE: res.value = {31'd0, a >= b};
         OP_EQ: res.value = {31'd0, a == b};
         OP_NE: res.value = {31'd0, a != b};
         OP_MIN: res.value = (a < b) ? a : b;
         OP_MAX: res.value = (a > b) ? a : b;
         OP_TOINT: begin
            wide = sa / (64'sd1 <<< FRAC_BITS);
            res.value = wide[31:0];
         end
         OP_FROMINT: res.value = a << FRAC_BITS;
         default: res.value = '0;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h (result %0d)", what, got, want, rsp_count);
      fail_count++;
   endtask

   assign pending = expected_results.size();

   initial begin
      fail_count = 0;
      rsp_count = 0;
   end

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compute_alu(req_tuser, req_tdata[31:0],
                                                   req_tdata[63:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.value) report_mismatch("value", rsp_tdata, want.value);
               if (rsp_tuser !== want.status) begin
                  report_mismatch("status", {31'd0, rsp_tuser}, {31'd0, want.status});
               end
            end
            rsp_count++;
         end
      end
   end

endmodule

// ===== tb/sv/tb_fixed_point_alu.sv =====
module tb_fixed_point_alu;
   import fpa_pkg::*;

   localparam int FracBits = 8;
   // wait margin used at the end of the run
   localparam int Latency = FracBits + 33;
   localparam int RandomItems = 1900;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // operand_a[31:0], operand_b[63:32]
   logic [4:0]  req_tuser = '0;   // op[4:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // value[31:0]
   logic        rsp_tuser;        // status

   int fail_count, pending, rsp_count;
   int cycle_count = 0;
   bit hold_rsp = 1'b0;
   int sent = 0;

   always #10 clock = ~clock;

   fixed_point_alu #(.FRAC_BITS(FracBits)) dut (.*);

   fpa_checker #(.FRAC_BITS(FracBits)) u_checker (.*);

   // Watchdog: fail the run if it drags past the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: ready windows, random stalls, forced long hold-off on request.
   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else if (cycle_count % 600 < 150) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      repeat (200) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Pick a field value biased toward the extremes and small values.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return $urandom_range(0, 1023) - 512;
         default: return $urandom;
      endcase
   endfunction

   // Present one item and hold it until the transfer completes.
   task automatic send_item(logic [4:0] op, logic [31:0] a, logic [31:0] b);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic idle_cycles(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] a, b;
      int burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every op on extreme operands, division by zero, equal min/max,
      // unused opcodes.
      for (int op = 0; op <= 16; op++) begin
         send_item(op[4:0], 32'h8000_0000, (op == OP_DIV) ? 32'h0 : 32'hffff_ffff);
      end
      send_item(OP_DIV, 32'h0000_0100, 32'h0000_0000);
      send_item(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
      send_item(OP_MIN, 32'h0000_1234, 32'h0000_1234);
      send_item(OP_MAX, 32'hffff_fe00, 32'hffff_fe00);
      send_item(OP_TOINT, 32'hffff_ff01, 32'h0);
      send_item(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(5'd17, 32'h1, 32'h2);
      send_item(5'd31, 32'hffff_ffff, 32'hffff_ffff);

      // Pause until everything in flight has come back.
      idle_cycles(1);
      while (pending != 0) @(posedge clock);

      // Random bursts with random gaps.
      while (sent < RandomItems + 25) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
            send_item(($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                      : 5'($urandom_range(0, 16)), a, b);
         end
         if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
      end
      idle_cycles(1);

      while (pending != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      $display("covered %0d items over all 17 operations, unused opcodes and divide by zero",
               sent);
      $display("%0d results checked under random stalls and a long output hold-off",
               rsp_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
